[design/rope_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rope_pkg;

  // table and index geometry
  localparam int unsigned MaxPairs = 256;
  localparam int unsigned IdxW     = $clog2(MaxPairs);
  localparam int unsigned CountW   = 9;
  localparam logic [CountW-1:0] PairCountReset = 9'd64;

  // field widths
  localparam int unsigned FreqW = 32;
  localparam int unsigned PosW  = 16;
  localparam int unsigned CompW = 16;

  // CORDIC datapath
  localparam int unsigned CordicSteps = 16;
  localparam int unsigned StepW       = $clog2(CordicSteps);
  localparam int unsigned VecW        = 36;  // component * 2^16 plus growth
  localparam int unsigned ZW          = 32;  // residual angle, turns Q0.32
  localparam int unsigned GainW       = 30;
  localparam logic [GainW-1:0] GainQ30 = 30'd652032874;

  typedef enum logic {
    ActLoad   = 1'b0,
    ActRotate = 1'b1
  } action_e;

  // tags riding along with a pair
  typedef struct packed {
    logic err;
    logic last;
  } side_t;

  // word handed from cell to cell
  typedef struct packed {
    logic signed [VecW-1:0] x;
    logic signed [VecW-1:0] y;
    logic signed [ZW-1:0]   z;
    side_t                  side;
  } cell_t;

  // round(atan(2^-i) / 2pi * 2^32)
  function automatic logic signed [ZW-1:0] atan_turns(input logic [StepW-1:0] step);
    logic signed [ZW-1:0] r;
    case (step)
      4'd0:    r = 32'sd536870912;
      4'd1:    r = 32'sd316933406;
      4'd2:    r = 32'sd167458907;
      4'd3:    r = 32'sd85004756;
      4'd4:    r = 32'sd42667331;
      4'd5:    r = 32'sd21354465;
      4'd6:    r = 32'sd10679838;
      4'd7:    r = 32'sd5340245;
      4'd8:    r = 32'sd2670163;
      4'd9:    r = 32'sd1335087;
      4'd10:   r = 32'sd667544;
      4'd11:   r = 32'sd333772;
      4'd12:   r = 32'sd166886;
      4'd13:   r = 32'sd83443;
      4'd14:   r = 32'sd41722;
      4'd15:   r = 32'sd20861;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[design/rope_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface rope_in_if;
  logic                             valid;
  logic                             ready;
  logic                             action;
  logic [7:0]                       pair_index;
  logic [rope_pkg::FreqW-1:0]       freq_word;
  logic [rope_pkg::PosW-1:0]        position;
  logic signed [rope_pkg::CompW-1:0] x_first;
  logic signed [rope_pkg::CompW-1:0] x_second;
  logic                             last_pair;

  modport source (
    output valid, action, pair_index, freq_word, position, x_first, x_second, last_pair,
    input  ready
  );
  modport sink (
    input  valid, action, pair_index, freq_word, position, x_first, x_second, last_pair,
    output ready
  );
endinterface

interface rope_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [rope_pkg::CompW-1:0] y_first;
  logic signed [rope_pkg::CompW-1:0] y_second;
  logic                              index_error;
  logic                              last_out;

  modport source (
    output valid, y_first, y_second, index_error, last_out,
    input  ready
  );
  modport sink (
    input  valid, y_first, y_second, index_error, last_out,
    output ready
  );
endinterface

interface rope_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [rope_pkg::CountW-1:0]   data;

  modport source (
    output valid, data,
    input  ready
  );
  modport sink (
    input  valid, data,
    output ready
  );
endinterface

`default_nettype wire

[design/rope_phase.sv]
`timescale 1ns / 1ps
`default_nettype none

// Table write/read, phase multiply, quadrant fold. Three stages.
module rope_phase (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  rope_in_if.sink                         in_i,
  input  wire logic [rope_pkg::CountW-1:0] pair_count_i,
  output logic                            valid_o,
  input  wire logic                       ready_i,
  output rope_pkg::cell_t                 data_o
);

  logic [rope_pkg::FreqW-1:0] freq_mem [rope_pkg::MaxPairs];

  // stage A: table read
  logic                              a_valid_q;
  logic [rope_pkg::FreqW-1:0]        a_freq_q;
  logic [rope_pkg::PosW-1:0]         a_pos_q;
  logic signed [rope_pkg::CompW-1:0] a_xf_q, a_xs_q;
  rope_pkg::side_t                   a_side_q;
  // stage B: phase
  logic                              b_valid_q;
  logic [rope_pkg::FreqW-1:0]        b_phase_q;
  logic signed [rope_pkg::CompW-1:0] b_xf_q, b_xs_q;
  rope_pkg::side_t                   b_side_q;
  // stage C: quadrant folded
  logic                              c_valid_q;
  rope_pkg::cell_t                   c_data_q, c_data_d;

  logic a_rdy, b_rdy, c_rdy;
  logic accept, is_rot;
  logic [rope_pkg::PosW+rope_pkg::FreqW-1:0] prod;

  assign c_rdy = !c_valid_q || ready_i;
  assign b_rdy = !b_valid_q || c_rdy;
  assign a_rdy = !a_valid_q || b_rdy;
  assign in_i.ready = a_rdy;

  assign accept = in_i.valid && a_rdy;
  assign is_rot = (rope_pkg::action_e'(in_i.action) == rope_pkg::ActRotate);

  // memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (accept && !is_rot) begin
      freq_mem[in_i.pair_index[rope_pkg::IdxW-1:0]] <= in_i.freq_word;
    end
    if (accept && is_rot) begin
      a_freq_q <= freq_mem[in_i.pair_index[rope_pkg::IdxW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && is_rot) begin
      a_pos_q       <= in_i.position;
      a_xf_q        <= in_i.x_first;
      a_xs_q        <= in_i.x_second;
      a_side_q.last <= in_i.last_pair;
      a_side_q.err  <= ({1'b0, in_i.pair_index} >= pair_count_i);
    end
  end

  assign prod = a_pos_q * a_freq_q;

  always_ff @(posedge clk_i) begin
    if (a_valid_q && b_rdy) begin
      b_phase_q <= prod[rope_pkg::FreqW-1:0];
      b_xf_q    <= a_xf_q;
      b_xs_q    <= a_xs_q;
      b_side_q  <= a_side_q;
    end
  end

  // center the residual on zero, fold whole quarter turns into swaps
  always_comb begin
    logic [rope_pkg::FreqW-1:0]       p2;
    logic signed [rope_pkg::VecW-1:0] xa, xb;
    p2 = b_phase_q + 32'h2000_0000;
    xa = {{4{b_xf_q[15]}}, b_xf_q, 16'h0000};
    xb = {{4{b_xs_q[15]}}, b_xs_q, 16'h0000};
    c_data_d.z    = $signed({2'b00, p2[29:0]}) - 32'sh2000_0000;
    c_data_d.side = b_side_q;
    case (p2[31:30])
      2'd0: begin
        c_data_d.x = xa;
        c_data_d.y = xb;
      end
      2'd1: begin
        c_data_d.x = -xb;
        c_data_d.y = xa;
      end
      2'd2: begin
        c_data_d.x = -xa;
        c_data_d.y = -xb;
      end
      default: begin
        c_data_d.x = xb;
        c_data_d.y = -xa;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (b_valid_q && c_rdy) begin
      c_data_q <= c_data_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else begin
      if (a_rdy) begin
        a_valid_q <= accept && is_rot;
      end
      if (b_rdy) begin
        b_valid_q <= a_valid_q;
      end
      if (c_rdy) begin
        c_valid_q <= b_valid_q;
      end
    end
  end

  assign valid_o = c_valid_q;
  assign data_o  = c_data_q;

endmodule

`default_nettype wire

[design/rope_cordic_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

// One CORDIC micro-rotation, registered.
module rope_cordic_cell (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic [rope_pkg::StepW-1:0] step_i,
  input  wire logic                       valid_i,
  output logic                            ready_o,
  input  wire rope_pkg::cell_t            data_i,
  output logic                            valid_o,
  input  wire logic                       ready_i,
  output rope_pkg::cell_t                 data_o
);

  logic            valid_q;
  rope_pkg::cell_t data_q, data_d;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    logic signed [rope_pkg::VecW-1:0] xs, ys;
    logic signed [rope_pkg::ZW-1:0]   ang;
    xs  = data_i.x >>> step_i;
    ys  = data_i.y >>> step_i;
    ang = rope_pkg::atan_turns(step_i);
    data_d.side = data_i.side;
    if (!data_i.z[rope_pkg::ZW-1]) begin
      data_d.x = data_i.x - ys;
      data_d.y = data_i.y + xs;
      data_d.z = data_i.z - ang;
    end else begin
      data_d.x = data_i.x + ys;
      data_d.y = data_i.y - xs;
      data_d.z = data_i.z + ang;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

[design/rope_gain.sv]
`timescale 1ns / 1ps
`default_nettype none

// Gain correction and saturation. Split multiply, then sum/round/clamp.
module rope_gain (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  output logic                 ready_o,
  input  wire rope_pkg::cell_t data_i,
  rope_out_if.source           out_o
);

  logic                  m_valid_q;
  logic signed [48:0]    m_xh_q, m_yh_q;
  logic [47:0]           m_xl_q, m_yl_q;
  rope_pkg::side_t       m_side_q;

  logic                               o_valid_q;
  logic signed [rope_pkg::CompW-1:0]  o_yf_q, o_ys_q;
  rope_pkg::side_t                    o_side_q;

  logic m_rdy, o_rdy;
  logic signed [rope_pkg::GainW:0] gain_s;

  assign o_rdy   = !o_valid_q || out_o.ready;
  assign m_rdy   = !m_valid_q || o_rdy;
  assign ready_o = m_rdy;
  assign gain_s  = $signed({1'b0, rope_pkg::GainQ30});

  // high half signed, low half unsigned
  always_ff @(posedge clk_i) begin
    if (valid_i && m_rdy) begin
      m_xh_q   <= $signed(data_i.x[35:18]) * gain_s;
      m_yh_q   <= $signed(data_i.y[35:18]) * gain_s;
      m_xl_q   <= {30'b0, data_i.x[17:0]} * {18'b0, rope_pkg::GainQ30};
      m_yl_q   <= {30'b0, data_i.y[17:0]} * {18'b0, rope_pkg::GainQ30};
      m_side_q <= data_i.side;
    end
  end

  function automatic logic signed [rope_pkg::CompW-1:0] finish(
    input logic signed [48:0] hi,
    input logic [47:0]        lo
  );
    logic signed [66:0] sum;
    logic signed [20:0] r;
    logic signed [rope_pkg::CompW-1:0] v;
    sum = $signed({hi, 18'b0}) + $signed({19'b0, lo}) + (67'sd1 <<< 45);
    r   = sum[66:46];
    if (r > 21'sd32767) begin
      v = 16'sh7fff;
    end else if (r < -21'sd32768) begin
      v = 16'sh8000;
    end else begin
      v = r[15:0];
    end
    return v;
  endfunction

  always_ff @(posedge clk_i) begin
    if (m_valid_q && o_rdy) begin
      o_side_q <= m_side_q;
      if (m_side_q.err) begin
        o_yf_q <= '0;
        o_ys_q <= '0;
      end else begin
        o_yf_q <= finish(m_xh_q, m_xl_q);
        o_ys_q <= finish(m_yh_q, m_yl_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (m_rdy) begin
        m_valid_q <= valid_i;
      end
      if (o_rdy) begin
        o_valid_q <= m_valid_q;
      end
    end
  end

  assign out_o.valid       = o_valid_q;
  assign out_o.y_first     = o_yf_q;
  assign out_o.y_second    = o_ys_q;
  assign out_o.index_error = o_side_q.err;
  assign out_o.last_out    = o_side_q.last;

endmodule

`default_nettype wire

[design/rotary_position_embedding_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// Rotary position embedding, one (first-half, second-half) pair per word.
// A load word (action 0) writes freq_word into the 256-entry inverse
// frequency table at pair_index and gives no result.
// A rotate word (action 1) reads the table, forms the phase as the low 32
// bits of position * freq (turns, Q0.32), folds whole quarter turns into a
// swap, then runs 16 CORDIC micro-rotations in a row of 16 registered cells
// and finally corrects the CORDIC gain and saturates to Q4.12. A rotate
// with pair_index >= pair_count returns zeros with index_error set.
// Throughput is one word per cycle while the output is not stalled; a
// rotate passes through table read, phase multiply, quadrant fold, 16 cells,
// and two gain stages (the 36x30 gain multiply is split into two partial products).
// Every stage has its own valid bit and takes a new word when it is empty
// or its neighbor moves on, so bubbles close up and input is still taken
// while the output word waits. Table entries hold garbage until loaded.
// pair_count resets to 64; write it only while the block is idle.
module rotary_position_embedding_core (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rope_in_if.sink   in_i,
  rope_out_if.source out_o,
  rope_cfg_if.sink  cfg_i
);

  localparam int unsigned Steps = rope_pkg::CordicSteps;

  logic [rope_pkg::CountW-1:0] pair_count_q;

  // cell chain: index 0 is the quadrant stage output
  logic            chain_valid [Steps+1];
  logic            chain_ready [Steps+1];
  rope_pkg::cell_t chain_data  [Steps+1];

  // configuration register, always ready
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair_count_q <= rope_pkg::PairCountReset;
    end else if (cfg_i.valid) begin
      pair_count_q <= cfg_i.data;
    end
  end

  rope_phase u_phase (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .pair_count_i(pair_count_q),
    .valid_o     (chain_valid[0]),
    .ready_i     (chain_ready[0]),
    .data_o      (chain_data[0])
  );

  for (genvar g = 0; g < Steps; g++) begin : g_cell
    rope_cordic_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .step_i (rope_pkg::StepW'(g)),
      .valid_i(chain_valid[g]),
      .ready_o(chain_ready[g]),
      .data_i (chain_data[g]),
      .valid_o(chain_valid[g+1]),
      .ready_i(chain_ready[g+1]),
      .data_o (chain_data[g+1])
    );
  end

  rope_gain u_gain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(chain_valid[Steps]),
    .ready_o(chain_ready[Steps]),
    .data_i (chain_data[Steps]),
    .out_o  (out_o)
  );

endmodule

`default_nettype wire

[test/rotary_position_embedding_core_tb.sv]
`timescale 1ns / 1ps

// RoPE core bench: a 256-entry inverse frequency table gets loaded and pairs
// get rotated through the CORDIC pipe. The checker below keeps its own table
// and pair_count, predicts every rotate word bit for bit, and matches the
// output words in order against the queue of predictions.
module rotary_position_embedding_core_tb;
  import rope_pkg::*;

  localparam int CycleLimit  = 400000;
  localparam int DrainCycles = 40;    // settle time after the last result comes back
  localparam int LongHold    = 120;   // output hold-off, fills the pipe
  localparam int MaxReports  = 100;   // cap on printed mismatch lines

  typedef struct {
    action_e                  action;
    logic [7:0]               pair_index;
    logic [FreqW-1:0]         freq_word;
    logic [PosW-1:0]          position;
    logic signed [CompW-1:0]  x_first;
    logic signed [CompW-1:0]  x_second;
    logic                     last_pair;
  } rope_word_t;

  typedef struct {
    logic signed [CompW-1:0] y_first;
    logic signed [CompW-1:0] y_second;
    logic                    index_error;
    logic                    last_out;
  } rope_result_t;

  // Predicts the rotated pair for every accepted rotate word and holds the
  // predictions until the matching output word shows up.
  class rope_checker;
    bit [FreqW-1:0]    freq_copy [MaxPairs];
    logic [CountW-1:0] pair_count;
    longint            atan_step [CordicSteps];
    rope_result_t      expected_pairs [$];
    int                errors;

    function new();
      pair_count = PairCountReset;
      errors     = 0;
      // atan(2^-i) in turns, Q0.32
      atan_step  = '{536870912, 316933406, 167458907, 85004756,
                     42667331, 21354465, 10679838, 5340245,
                     2670163, 1335087, 667544, 333772,
                     166886, 83443, 41722, 20861};
    endfunction

    // gain correction (K in Q30), round half up, then clamp to Q4.12
    function logic signed [CompW-1:0] apply_gain(longint v);
      longint g;
      g = (v * 64'sd652032874 + 64'sh2000_0000_0000) >>> 46;
      if (g > 32767)
        g = 32767;
      else if (g < -32768)
        g = -32768;
      return g[CompW-1:0];
    endfunction

    function rope_result_t predict_rotation(logic [31:0] phase,
                                            logic signed [CompW-1:0] a,
                                            logic signed [CompW-1:0] b);
      rope_result_t r;
      logic [31:0]  p2;
      longint       x, y, z, t, xs;
      // shift by 1/8 turn so the top two bits pick the nearest quadrant
      p2 = phase + 32'h2000_0000;
      z  = longint'(p2[29:0]) - 64'sh2000_0000;
      x  = longint'(a) <<< 16;
      y  = longint'(b) <<< 16;
      for (int q = 0; q < p2[31:30]; q++) begin
        t = x;
        x = -y;
        y = t;
      end
      for (int i = 0; i < CordicSteps; i++) begin
        xs = x >>> i;
        if (z >= 0) begin
          x = x - (y >>> i);
          y = y + xs;
          z = z - atan_step[i];
        end else begin
          x = x + (y >>> i);
          y = y - xs;
          z = z + atan_step[i];
        end
      end
      r.y_first  = apply_gain(x);
      r.y_second = apply_gain(y);
      return r;
    endfunction

    function void note_word(rope_word_t w);
      rope_result_t r;
      logic [47:0]  turns;
      if (w.action == ActLoad) begin
        // loads go in regardless of pair_count
        freq_copy[w.pair_index] = w.freq_word;
        return;
      end
      if ({1'b0, w.pair_index} >= pair_count) begin
        r.y_first     = '0;
        r.y_second    = '0;
        r.index_error = 1'b1;
      end else begin
        turns         = w.position * freq_copy[w.pair_index];
        r             = predict_rotation(turns[31:0], w.x_first, w.x_second);
        r.index_error = 1'b0;
      end
      r.last_out = w.last_pair;
      expected_pairs.push_back(r);
    endfunction

    function void compare(string field, logic signed [CompW-1:0] want,
                          logic signed [CompW-1:0] got);
      if (got !== want) begin
        errors++;
        if (errors <= MaxReports)
          $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
      end
    endfunction

    function void check_word(rope_result_t got);
      rope_result_t want;
      if (expected_pairs.size() == 0) begin
        errors++;
        if (errors <= MaxReports)
          $display("%0t: unexpected word expected none actual %0d %0d %0b %0b", $time,
                   got.y_first, got.y_second, got.index_error, got.last_out);
        return;
      end
      want = expected_pairs.pop_front();
      compare("y_first", want.y_first, got.y_first);
      compare("y_second", want.y_second, got.y_second);
      compare("index_error", want.index_error, got.index_error);
      compare("last_out", want.last_out, got.last_out);
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  rope_in_if  in_if ();
  rope_out_if out_if ();
  rope_cfg_if cfg_if ();

  rotary_position_embedding_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  rope_checker sb = new();

  bit loaded [MaxPairs];   // entries written since reset
  bit quiet        = 1'b0; // no idling on either side
  bit hold_out_req = 1'b0; // asks the sink for one long hold-off
  int cycle_count  = 0;

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // hard stop in case the pipe hangs
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("%0t: timeout, %0d words still expected", $time, sb.expected_pairs.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic rope_word_t make_word(action_e act, logic [7:0] idx,
                                           logic [FreqW-1:0] freq, logic [PosW-1:0] pos,
                                           logic signed [CompW-1:0] a,
                                           logic signed [CompW-1:0] b, logic last);
    rope_word_t w;
    w.action     = act;
    w.pair_index = idx;
    w.freq_word  = freq;
    w.position   = pos;
    w.x_first    = a;
    w.x_second   = b;
    w.last_pair  = last;
    return w;
  endfunction

  // mix of full-range, tiny (realistic) and exact eighth-turn frequencies
  function automatic logic [FreqW-1:0] random_freq();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 32'h00FF_FFFF);
      1:       return {3'($urandom_range(0, 7)), 29'd0};
      default: return $urandom();
    endcase
  endfunction

  function automatic logic signed [CompW-1:0] random_comp();
    case ($urandom_range(0, 11))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return '0;
      default: return CompW'($urandom());
    endcase
  endfunction

  function automatic rope_word_t random_word();
    rope_word_t       w;
    logic [7:0]       idx;
    logic [PosW-1:0]  pos;
    logic [CountW-1:0] top;
    // mostly in-range indexes, some anywhere to hit index errors
    top = (sb.pair_count > MaxPairs) ? CountW'(MaxPairs) : sb.pair_count;
    if (top != 0 && $urandom_range(0, 9) < 7)
      idx = 8'($urandom_range(0, top - 1));
    else
      idx = 8'($urandom_range(0, 255));
    pos = ($urandom_range(0, 1) == 0) ? PosW'($urandom_range(0, 65535))
                                      : PosW'($urandom_range(0, 2047));
    w = make_word(($urandom_range(0, 3) == 0) ? ActLoad : ActRotate, idx, random_freq(),
                  pos, random_comp(), random_comp(), 1'($urandom_range(0, 1)));
    return w;
  endfunction

  // valid stays up from word to word; it only drops in a pause or a drain
  task automatic send_word(input rope_word_t w);
    in_if.valid      <= 1'b1;
    in_if.action     <= w.action;
    in_if.pair_index <= w.pair_index;
    in_if.freq_word  <= w.freq_word;
    in_if.position   <= w.position;
    in_if.x_first    <= w.x_first;
    in_if.x_second   <= w.x_second;
    in_if.last_pair  <= w.last_pair;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    sb.note_word(w);
    if (w.action == ActLoad)
      loaded[w.pair_index] = 1'b1;
  endtask

  // an in-range rotate must never read an unloaded entry: load it first
  task automatic offer_word(input rope_word_t w);
    if (w.action == ActRotate && {1'b0, w.pair_index} < sb.pair_count &&
        !loaded[w.pair_index])
      send_word(make_word(ActLoad, w.pair_index, random_freq(), PosW'($urandom()),
                          random_comp(), random_comp(), 1'($urandom_range(0, 1))));
    send_word(w);
  endtask

  task automatic pause_input(input int cycles);
    in_if.valid <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // hold the input until every predicted word is back, then let loads settle
  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (sb.expected_pairs.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_pair_count(input logic [CountW-1:0] value);
    drain_results();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    cfg_if.valid <= 1'b0;
    sb.pair_count = value;
  endtask

  task automatic run_random(input int n);
    for (int k = 0; k < n; k++) begin
      if (!quiet && $urandom_range(0, 7) == 0)
        pause_input($urandom_range(1, 12));
      offer_word(random_word());
    end
  endtask

  // output side: random stall bursts, one long hold-off on request
  initial begin : result_sink
    int           stall_left;
    rope_result_t got;
    stall_left   = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
        got.y_first     = out_if.y_first;
        got.y_second    = out_if.y_second;
        got.index_error = out_if.index_error;
        got.last_out    = out_if.last_out;
        sb.check_word(got);
      end
      if (hold_out_req) begin
        hold_out_req = 1'b0;
        stall_left   = LongHold;
      end else if (stall_left == 0 && !quiet && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 12);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    rst_ni           = 1'b0;
    in_if.valid      = 1'b0;
    in_if.action     = ActLoad;
    in_if.pair_index = '0;
    in_if.freq_word  = '0;
    in_if.position   = '0;
    in_if.x_first    = '0;
    in_if.x_second   = '0;
    in_if.last_pair  = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.data      = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, pair_count at its reset value of 64
    send_word(make_word(ActLoad, 8'd0, 32'h0000_0000, 16'hFFFF, 16'sh7FFF, 16'sh8000, 1'b1));
    send_word(make_word(ActLoad, 8'd255, 32'hFFFF_FFFF, 16'h0000, 16'sh0, 16'sh0, 1'b0));
    send_word(make_word(ActLoad, 8'd1, 32'h2000_0000, 16'd0, 16'sh0, 16'sh0, 1'b0));
    send_word(make_word(ActLoad, 8'd2, 32'h4000_0000, 16'd0, 16'sh0, 16'sh0, 1'b0));
    send_word(make_word(ActLoad, 8'd63, 32'h8000_0000, 16'd0, 16'sh0, 16'sh0, 1'b0));
    send_word(make_word(ActLoad, 8'd3, 32'hC000_0000, 16'd0, 16'sh0, 16'sh0, 1'b0));
    // beyond pair_count, still stored
    send_word(make_word(ActLoad, 8'd200, 32'h1234_5678, 16'd0, 16'sh0, 16'sh0, 1'b0));
    // zero frequency: no rotation, extreme inputs
    send_word(make_word(ActRotate, 8'd0, 32'd0, 16'hFFFF, 16'sh7FFF, 16'sh8000, 1'b1));
    send_word(make_word(ActRotate, 8'd0, 32'd0, 16'd0, 16'sh0, 16'sh0, 1'b0));
    // 45 then 90 degrees on full-scale pairs: an output saturates
    send_word(make_word(ActRotate, 8'd1, 32'd0, 16'd1, 16'sh7FFF, 16'sh7FFF, 1'b0));
    send_word(make_word(ActRotate, 8'd2, 32'd0, 16'd1, 16'sh8000, 16'sh8000, 1'b1));
    // half turn: negating -32768 clamps
    send_word(make_word(ActRotate, 8'd63, 32'd0, 16'd1, 16'sh7FFF, 16'sh8000, 1'b0));
    send_word(make_word(ActRotate, 8'd3, 32'd0, 16'd3, 16'sh1000, 16'shF000, 1'b0));
    // phase wraps many times
    send_word(make_word(ActRotate, 8'd1, 32'd0, 16'hFFFF, 16'sh1234, 16'sh8765, 1'b1));
    // index errors: at count, at top of range, on an entry loaded beyond count
    send_word(make_word(ActRotate, 8'd64, 32'd0, 16'd5, 16'sh7FFF, 16'sh7FFF, 1'b0));
    send_word(make_word(ActRotate, 8'd255, 32'd0, 16'hFFFF, 16'sh8000, 16'sh7FFF, 1'b1));
    send_word(make_word(ActRotate, 8'd200, 32'd0, 16'd9, 16'sh0100, 16'sh0200, 1'b0));

    // full table in use; long output hold-off mid-phase, then a full drain
    write_pair_count(9'd256);
    send_word(make_word(ActRotate, 8'd255, 32'd0, 16'hFFFF, 16'sh7FFF, 16'sh8000, 1'b1));
    send_word(make_word(ActRotate, 8'd200, 32'd0, 16'd777, 16'shC000, 16'sh3FFF, 1'b0));
    run_random(100);
    hold_out_req = 1'b1;
    run_random(100);
    drain_results();
    run_random(100);

    // smallest count with an in-range index
    write_pair_count(9'd1);
    run_random(150);

    // zero: every rotate is an index error, loads still land
    write_pair_count(9'd0);
    run_random(60);

    // above the table size
    write_pair_count(9'd511);
    run_random(150);

    // some count in between; last stretch runs at full rate
    write_pair_count(CountW'($urandom_range(2, 255)));
    run_random(150);
    quiet = 1'b1;
    run_random(150);

    drain_results();
    if (sb.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
